// ===== hw/rtl/ymc_pkg.sv =====
// Shared types, codes and functions of the YModem-CRC receiver.
`default_nettype none
package ymc_pkg;
    localparam int SIZE_DIGITS_DEF = 16;
    localparam logic [31:0] BASE_RST = 32'h0;
    localparam logic [31:0] LIMIT_RST = 32'h0010_0000;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [7:0] ERRLIM_RST = 8'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_ERRLIM = 2'd3;

    // Input functions
    localparam logic [1:0] FN_BYTE = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_FLASH = 2'd2;

    // Result kinds
    localparam logic [2:0] K_SEND = 3'd0;
    localparam logic [2:0] K_PAYLOAD = 3'd1;
    localparam logic [2:0] K_COMMIT = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_INFO = 3'd4;
    localparam logic [2:0] K_ERASE = 3'd5;
    localparam logic [2:0] K_END = 3'd6;

    // Session status
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ABORT = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_FLASH = 2'd3;

    // Protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CA = 8'h18;
    localparam logic [7:0] CH_POLL = 8'h43;
    localparam logic [7:0] CH_AB1 = 8'h41;
    localparam logic [7:0] CH_AB2 = 8'h61;

    localparam int MAX_RES = 4;

    // All results caused by one input item
    typedef struct packed {
        logic [2:0]                 n;
        logic [MAX_RES-1:0][2:0]    kind;
        logic [MAX_RES-1:0][7:0]    byte_v;
        logic [31:0]                addr;
        logic [10:0]                cnt;
        logic [31:0]                fsize;
        logic [1:0]                 status;
    } t_bundle;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ymc_front.sv =====
// Protocol front end: takes events, updates session state, builds result bundles.
`default_nettype none
module ymc_front #(
    parameter int SIZE_DIGITS = ymc_pkg::SIZE_DIGITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [1:0]      i_func,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_flash_ok,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_full,
    output logic                 o_push,
    output ymc_pkg::t_bundle     o_bundle
);
    import ymc_pkg::*;

    localparam int SDW = $clog2(SIZE_DIGITS + 1);

    localparam logic [2:0] PH_HDR = 3'd0;
    localparam logic [2:0] PH_CA2 = 3'd1;
    localparam logic [2:0] PH_NUM = 3'd2;
    localparam logic [2:0] PH_CNUM = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRCH = 3'd5;
    localparam logic [2:0] PH_CRCL = 3'd6;
    localparam logic [2:0] PH_FLASH = 3'd7;

    localparam logic [1:0] SP_NAME = 2'd0;
    localparam logic [1:0] SP_SIZE = 2'd1;
    localparam logic [1:0] SP_DONE = 2'd2;
    localparam logic [1:0] SP_BAD = 2'd3;

    logic [31:0] r_base, r_limit;
    logic [15:0] r_timeout;
    logic [7:0]  r_errlim;

    logic [2:0]  r_phase, n_phase;
    logic [10:0] r_body_len, n_body_len, r_idx, n_idx;
    logic [7:0]  r_blk, n_blk, r_exp, n_exp, r_errs, n_errs;
    logic [15:0] r_crc, n_crc, r_rcrc, n_rcrc, r_ticks, n_ticks;
    logic        r_started, n_started, r_hseen, n_hseen;
    logic        r_num_ok, n_num_ok, r_hempty, n_hempty;
    logic [31:0] r_waddr, n_waddr;
    logic [1:0]  r_sp, n_sp;
    logic [SDW-1:0] r_sd, n_sd;
    logic [31:0] r_sv, n_sv;

    logic accept;
    t_bundle bnd;

    assign o_stall = i_full;
    assign accept = i_valid && !i_full;

    always_comb begin
        logic do_err, do_rst, mism, data, good;
        logic [31:0] fsize;
        logic [35:0] t;
        logic [7:0]  b;
        do_err = 1'b0;
        do_rst = 1'b0;
        b = i_rx_byte;
        t = '0;
        fsize = '0;
        n_phase = r_phase; n_body_len = r_body_len; n_idx = r_idx; n_blk = r_blk;
        n_exp = r_exp; n_errs = r_errs; n_crc = r_crc; n_rcrc = r_rcrc;
        n_ticks = r_ticks; n_started = r_started; n_hseen = r_hseen;
        n_num_ok = r_num_ok; n_hempty = r_hempty; n_waddr = r_waddr;
        n_sp = r_sp; n_sd = r_sd; n_sv = r_sv;
        bnd = '0;
        mism = (r_blk != 8'd0) && (r_blk != r_exp);
        data = r_num_ok && !mism && (r_exp != 8'd0);
        good = r_num_ok && (r_crc == {r_rcrc[15:8], b});

        if (accept) begin
            if (i_func == FN_BYTE && r_phase != PH_FLASH) begin
                unique case (r_phase)
                    PH_HDR: begin
                        if (b == CH_SOH || b == CH_STX) begin
                            n_body_len = (b == CH_SOH) ? 11'd128 : 11'd1024;
                            n_phase = PH_NUM;
                            n_ticks = '0;
                        end else if (b == CH_EOT) begin
                            n_errs = '0;
                            if (r_hseen) begin
                                n_hseen = 1'b0;
                                bnd.kind[0] = K_SEND; bnd.byte_v[0] = CH_NAK; bnd.n = 3'd1;
                            end else begin
                                bnd.byte_v[0] = CH_ACK; bnd.byte_v[1] = CH_POLL; bnd.n = 3'd2;
                            end
                            n_exp = '0;
                            n_ticks = '0;
                        end else if (b == CH_CA) begin
                            n_phase = PH_CA2;
                            n_ticks = '0;
                        end else if (b == CH_AB1 || b == CH_AB2) begin
                            bnd.byte_v[0] = CH_CA; bnd.byte_v[1] = CH_CA;
                            bnd.kind[2] = K_END; bnd.status = ST_ABORT; bnd.n = 3'd3;
                            do_rst = 1'b1;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    PH_CA2: begin
                        if (b == CH_CA) begin
                            bnd.byte_v[0] = CH_ACK; bnd.kind[1] = K_END;
                            bnd.status = ST_ABORT; bnd.n = 3'd2;
                            do_rst = 1'b1;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                    PH_NUM: begin
                        n_blk = b;
                        n_phase = PH_CNUM;
                    end
                    PH_CNUM: begin
                        n_num_ok = (b == ~r_blk);
                        n_crc = '0; n_idx = '0;
                        n_sp = SP_NAME; n_sd = '0; n_sv = '0; n_hempty = 1'b0;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        n_crc = crc_step(r_crc, b);
                        if (r_num_ok && !mism) begin
                            if (r_exp != 8'd0) begin
                                bnd.kind[0] = K_PAYLOAD; bnd.byte_v[0] = b;
                                bnd.addr = r_waddr + {21'd0, r_idx}; bnd.n = 3'd1;
                            end else if (r_sp == SP_NAME) begin
                                if (b == 8'd0) begin
                                    if (r_idx == 11'd0) n_hempty = 1'b1;
                                    n_sp = SP_SIZE; n_sd = '0; n_sv = '0;
                                end
                            end else if (r_sp == SP_SIZE) begin
                                if (b == 8'h20 || b == 8'h00) begin
                                    n_sp = SP_DONE;
                                end else if ((b == 8'h6B || b == 8'h4B) && r_sd != '0) begin
                                    n_sv = (r_sv > 32'h003F_FFFF) ? '1 : (r_sv << 10);
                                    n_sp = SP_DONE;
                                end else if ((b == 8'h6D || b == 8'h4D) && r_sd != '0) begin
                                    n_sv = (r_sv > 32'h0000_0FFF) ? '1 : (r_sv << 20);
                                    n_sp = SP_DONE;
                                end else if (b >= 8'h30 && b <= 8'h39) begin
                                    if (r_sd >= SDW'(10)) begin
                                        n_sp = SP_BAD;
                                    end else begin
                                        t = ({4'd0, r_sv} << 3) + ({4'd0, r_sv} << 1)
                                            + {28'd0, b - 8'h30};
                                        n_sv = (t[35:32] != 4'd0) ? '1 : t[31:0];
                                        n_sd = r_sd + SDW'(1);
                                        if (n_sd >= SDW'(SIZE_DIGITS)) n_sp = SP_DONE;
                                    end
                                end else begin
                                    n_sp = SP_BAD;
                                end
                            end
                        end
                        n_idx = r_idx + 11'd1;
                        if (n_idx >= r_body_len) n_phase = PH_CRCH;
                    end
                    PH_CRCH: begin
                        n_rcrc = {b, 8'h00};
                        n_phase = PH_CRCL;
                    end
                    PH_CRCL: begin
                        n_rcrc = {r_rcrc[15:8], b};
                        n_phase = PH_HDR;
                        n_ticks = '0;
                        if (!good) begin
                            if (data) begin
                                bnd.kind[0] = K_DISCARD; bnd.addr = r_waddr;
                                bnd.cnt = r_body_len; bnd.n = 3'd1;
                            end
                            do_err = 1'b1;
                        end else begin
                            n_errs = '0;
                            fsize = (r_sp == SP_DONE || r_sp == SP_SIZE) ? r_sv : '0;
                            if (mism) begin
                                bnd.byte_v[0] = CH_NAK; bnd.n = 3'd1;
                            end else if (data) begin
                                bnd.kind[0] = K_COMMIT; bnd.addr = r_waddr;
                                bnd.cnt = r_body_len; bnd.n = 3'd1;
                                n_phase = PH_FLASH;
                            end else if (r_hempty) begin
                                bnd.byte_v[0] = CH_ACK; bnd.kind[1] = K_END;
                                bnd.status = ST_DONE; bnd.n = 3'd2;
                                do_rst = 1'b1;
                            end else if (fsize > r_limit) begin
                                bnd.byte_v[0] = CH_CA; bnd.byte_v[1] = CH_CA;
                                bnd.kind[2] = K_END; bnd.status = ST_LIMIT; bnd.n = 3'd3;
                                do_rst = 1'b1;
                            end else begin
                                if (!r_started) n_waddr = r_base;
                                bnd.kind[0] = K_ERASE; bnd.addr = r_base;
                                bnd.kind[1] = K_INFO; bnd.fsize = fsize;
                                bnd.byte_v[2] = CH_ACK; bnd.byte_v[3] = CH_POLL;
                                bnd.n = 3'd4;
                                n_hseen = 1'b1;
                                n_exp = r_exp + 8'd1;
                                n_started = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_func == FN_TICK && r_phase != PH_FLASH) begin
                if (r_ticks != 16'hFFFF) n_ticks = r_ticks + 16'd1;
                if (n_ticks > r_timeout) do_err = 1'b1;
            end else if (i_func == FN_FLASH && r_phase == PH_FLASH) begin
                n_phase = PH_HDR;
                n_ticks = '0;
                if (i_flash_ok) begin
                    n_waddr = r_waddr + {21'd0, r_body_len};
                    bnd.byte_v[0] = CH_ACK; bnd.n = 3'd1;
                    n_exp = r_exp + 8'd1;
                    n_started = 1'b1;
                end else begin
                    bnd.byte_v[0] = CH_CA; bnd.byte_v[1] = CH_CA;
                    bnd.kind[2] = K_END; bnd.status = ST_FLASH; bnd.n = 3'd3;
                    do_rst = 1'b1;
                end
            end

            if (do_err) begin
                if (r_started && n_errs != 8'hFF) n_errs = n_errs + 8'd1;
                n_phase = PH_HDR;
                n_ticks = '0;
                if (n_errs > r_errlim) begin
                    bnd.kind[bnd.n[1:0]] = K_SEND; bnd.byte_v[bnd.n[1:0]] = CH_CA;
                    bnd.n = bnd.n + 3'd1;
                    bnd.kind[bnd.n[1:0]] = K_SEND; bnd.byte_v[bnd.n[1:0]] = CH_CA;
                    bnd.n = bnd.n + 3'd1;
                    bnd.kind[bnd.n[1:0]] = K_END; bnd.status = ST_ABORT;
                    bnd.n = bnd.n + 3'd1;
                    do_rst = 1'b1;
                end else begin
                    bnd.kind[bnd.n[1:0]] = K_SEND; bnd.byte_v[bnd.n[1:0]] = CH_POLL;
                    bnd.n = bnd.n + 3'd1;
                end
            end

            if (do_rst) begin
                n_phase = PH_HDR; n_body_len = '0; n_idx = '0; n_blk = '0;
                n_crc = '0; n_rcrc = '0; n_exp = '0; n_errs = '0; n_ticks = '0;
                n_started = 1'b0; n_hseen = 1'b0; n_num_ok = 1'b0; n_hempty = 1'b0;
                n_waddr = r_base; n_sp = SP_NAME; n_sd = '0; n_sv = '0;
            end
        end
    end

    assign o_push = accept && (bnd.n != 3'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST; r_limit <= LIMIT_RST;
            r_timeout <= TIMEOUT_RST; r_errlim <= ERRLIM_RST;
            r_phase <= PH_HDR; r_body_len <= '0; r_idx <= '0; r_blk <= '0;
            r_exp <= '0; r_errs <= '0; r_crc <= '0; r_rcrc <= '0; r_ticks <= '0;
            r_started <= 1'b0; r_hseen <= 1'b0; r_num_ok <= 1'b0; r_hempty <= 1'b0;
            r_waddr <= BASE_RST; r_sp <= SP_NAME; r_sd <= '0; r_sv <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE:    r_base <= i_cfg_data;
                    CFG_LIMIT:   r_limit <= i_cfg_data;
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                    CFG_ERRLIM:  r_errlim <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase; r_body_len <= n_body_len; r_idx <= n_idx; r_blk <= n_blk;
            r_exp <= n_exp; r_errs <= n_errs; r_crc <= n_crc; r_rcrc <= n_rcrc;
            r_ticks <= n_ticks; r_started <= n_started; r_hseen <= n_hseen;
            r_num_ok <= n_num_ok; r_hempty <= n_hempty; r_waddr <= n_waddr;
            r_sp <= n_sp; r_sd <= n_sd; r_sv <= n_sv;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ymc_queue.sv =====
// Two-entry bundle queue between the front end and the result sequencer.
`default_nettype none
module ymc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ymc_pkg::t_bundle i_bundle,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output ymc_pkg::t_bundle      o_head
);
    import ymc_pkg::*;

    t_bundle r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_head.n != 3'd0) else $error("empty bundle queued");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/ymc_back.sv =====
// Result sequencer: plays out the records of the head bundle one per transfer.
`default_nettype none
module ymc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_have,
    input  wire ymc_pkg::t_bundle i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_byte_value,
    output logic [31:0]           o_address,
    output logic [10:0]           o_count,
    output logic [31:0]           o_image_size,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    import ymc_pkg::*;

    logic [1:0] r_sel;
    logic [2:0] k;
    logic xfer;

    assign k = i_head.kind[r_sel];
    assign o_valid = i_have;
    assign xfer = i_have && !i_stall;
    assign o_last = ({1'b0, r_sel} == i_head.n - 3'd1);
    assign o_pop = xfer && o_last;

    assign o_kind = k;
    assign o_byte_value = (k == K_SEND || k == K_PAYLOAD) ? i_head.byte_v[r_sel] : 8'd0;
    assign o_address = (k == K_PAYLOAD || k == K_COMMIT || k == K_DISCARD || k == K_ERASE)
                       ? i_head.addr : 32'd0;
    assign o_count = (k == K_COMMIT || k == K_DISCARD) ? i_head.cnt : 11'd0;
    assign o_image_size = (k == K_INFO) ? i_head.fsize : 32'd0;
    assign o_status = (k == K_END) ? i_head.status : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (xfer) begin
            r_sel <= o_last ? 2'd0 : r_sel + 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ymodem_crc_receiver.sv =====
// Top level of the YModem-CRC receiver.
`default_nettype none
// YModem-CRC receiver. Each input transfer carries one event: a received byte
// (func 0), a timer tick (func 1) or a flash write outcome (func 2). The front
// end handles every event combinationally (header decode, block number check,
// CRC-16/XMODEM, size parse from packet 0) and packs all results of that event,
// up to four, into one bundle. A two-entry queue sits between front end and the
// result sequencer, so input and output stall independently. Input rate is one
// event per cycle while the queue has room; output is one result per cycle while
// i_stall is low, and an event with N results takes N output transfers. Events
// that make no result never touch the queue. No clearing pass after reset.
module ymodem_crc_receiver #(
    parameter int SIZE_DIGITS = ymc_pkg::SIZE_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_flash_ok,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [31:0]      o_address,
    output logic [10:0]      o_count,
    output logic [31:0]      o_image_size,
    output logic [1:0]       o_status,
    output logic             o_last
);
    import ymc_pkg::*;

    t_bundle push_bnd, head_bnd;
    logic    push, full, pop, have;

    // front end: event decode and session state
    ymc_front #(.SIZE_DIGITS(SIZE_DIGITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_rx_byte, .i_flash_ok,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_full(full), .o_push(push), .o_bundle(push_bnd)
    );

    // decoupling queue
    ymc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(push_bnd), .o_full(full),
        .i_pop(pop), .o_valid(have), .o_head(head_bnd)
    );

    // back end: one result per transfer
    ymc_back u_back (
        .i_clk, .i_rst_n, .i_have(have), .i_head(head_bnd), .o_pop(pop),
        .o_valid, .i_stall, .o_kind, .o_byte_value, .o_address, .o_count,
        .o_image_size, .o_status, .o_last
    );
endmodule
`default_nettype wire

// ===== test/tb_ymodem_crc_receiver.sv =====
// Self-checking testbench of the YModem-CRC receiver: directed sessions, then random ones.
`timescale 1ns / 1ps

module tb_ymodem_crc_receiver;
    import ymc_pkg::*;

    localparam logic [1:0] FN_SPARE = 2'd3;   // unused function code, must be ignored
    localparam int IDLE_LIMIT = 5000;         // watchdog: cycles without any transfer
    localparam int PHASE_ITEMS = 75;          // random budget per register setting

    typedef enum logic [2:0] {
        PH_HDR, PH_CA2, PH_NUM, PH_CNUM, PH_DATA, PH_CRCH, PH_CRCL, PH_FLASH
    } t_rx_phase;

    typedef enum logic [1:0] {SP_NAME, SP_SIZE, SP_DONE, SP_BAD} t_size_scan;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] address;
        logic [10:0] count;
        logic [31:0] image_size;
        logic [1:0]  status;
        logic        last;
    } t_rx_result;

    // Mirror of the receiver: tracks protocol state, queues the results each event must
    // produce and matches them against what comes out.
    class ymodem_receiver_mirror;
        logic [31:0] base_address = BASE_RST;
        logic [31:0] size_limit = LIMIT_RST;
        logic [15:0] timeout_ticks = TIMEOUT_RST;
        logic [7:0]  error_limit = ERRLIM_RST;

        t_rx_phase   phase;
        logic [10:0] body_length, byte_index;
        logic [7:0]  block_number, expected_block, error_count;
        logic [15:0] crc_acc, rx_crc, tick_count;
        bit          session_started, header_seen, number_ok, header_empty;
        logic [31:0] write_address, size_value;
        t_size_scan  size_state;
        int          size_digits;

        t_rx_result  due[$];
        t_rx_result  step_res[$];
        int          mismatches = 0;
        int          ends = 0;

        function new();
            restart();
        endfunction

        static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            return c;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_BASE:    base_address = val;
                CFG_LIMIT:   size_limit = val;
                CFG_TIMEOUT: timeout_ticks = val[15:0];
                CFG_ERRLIM:  error_limit = val[7:0];
                default: ;
            endcase
        endfunction

        function void restart();
            phase = PH_HDR;
            body_length = 0; byte_index = 0; block_number = 0;
            crc_acc = 0; rx_crc = 0; expected_block = 0;
            error_count = 0; tick_count = 0;
            session_started = 0; header_seen = 0; number_ok = 0; header_empty = 0;
            write_address = base_address;
            size_state = SP_NAME; size_digits = 0; size_value = 0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] bv, logic [31:0] addr,
                           logic [10:0] cnt, logic [31:0] fs, logic [1:0] st);
            t_rx_result r;
            r = '{k, bv, addr, cnt, fs, st, 1'b0};
            if (step_res.size() < MAX_RES) step_res.push_back(r);
        endfunction

        function void send(logic [7:0] b);
            emit(K_SEND, b, 0, 0, 0, 0);
        endfunction

        function void end_session(logic [1:0] st);
            emit(K_END, 0, 0, 0, 0, st);
            ends++;
            restart();
        endfunction

        function void cancel(logic [1:0] st);
            send(CH_CA);
            send(CH_CA);
            end_session(st);
        endfunction

        function void error_event();
            if (session_started && error_count < 8'd255) error_count++;
            phase = PH_HDR;
            tick_count = 0;
            if (error_count > error_limit) cancel(ST_ABORT);
            else send(CH_POLL);
        endfunction

        function void parse_size(logic [7:0] b);
            logic [31:0] d;
            if (size_state == SP_NAME) begin
                if (b == 0) begin
                    if (byte_index == 0) header_empty = 1;
                    size_state = SP_SIZE;
                    size_digits = 0;
                    size_value = 0;
                end
                return;
            end
            if (size_state != SP_SIZE) return;
            if (b == " " || b == 0) begin
                size_state = SP_DONE;
            end else if ((b == "k" || b == "K") && size_digits > 0) begin
                size_value = (size_value > (32'hFFFF_FFFF >> 10)) ? 32'hFFFF_FFFF
                                                                   : size_value << 10;
                size_state = SP_DONE;
            end else if ((b == "m" || b == "M") && size_digits > 0) begin
                size_value = (size_value > (32'hFFFF_FFFF >> 20)) ? 32'hFFFF_FFFF
                                                                   : size_value << 20;
                size_state = SP_DONE;
            end else if (b >= "0" && b <= "9") begin
                d = b - "0";
                if (size_digits >= 10) begin
                    size_state = SP_BAD;
                    return;
                end
                if (size_value > (32'hFFFF_FFFF - d) / 10) size_value = 32'hFFFF_FFFF;
                else size_value = size_value * 10 + d;
                size_digits++;
                if (size_digits >= SIZE_DIGITS_DEF) size_state = SP_DONE;
            end else begin
                size_state = SP_BAD;
            end
        endfunction

        function bit number_mismatch();
            return block_number != 0 && block_number != expected_block;
        endfunction

        function void finish_packet();
            bit is_data, good;
            logic [31:0] fsize;
            is_data = number_ok && !number_mismatch() && expected_block != 0;
            good = number_ok && crc_acc == rx_crc;
            phase = PH_HDR;
            tick_count = 0;
            if (!good) begin
                if (is_data) emit(K_DISCARD, 0, write_address, body_length, 0, 0);
                error_event();
                return;
            end
            error_count = 0;
            if (number_mismatch()) begin
                send(CH_NAK);
                return;
            end
            if (is_data) begin
                emit(K_COMMIT, 0, write_address, body_length, 0, 0);
                phase = PH_FLASH;
                return;
            end
            if (header_empty) begin
                send(CH_ACK);
                end_session(ST_DONE);
                return;
            end
            fsize = (size_state == SP_DONE || size_state == SP_SIZE) ? size_value : 0;
            if (fsize > size_limit) begin
                cancel(ST_LIMIT);
                return;
            end
            if (!session_started) write_address = base_address;
            emit(K_ERASE, 0, base_address, 0, 0, 0);
            emit(K_INFO, 0, 0, 0, fsize, 0);
            send(CH_ACK);
            send(CH_POLL);
            header_seen = 1;
            expected_block++;
            session_started = 1;
        endfunction

        function void on_byte(logic [7:0] b);
            case (phase)
                PH_HDR: begin
                    if (b == CH_SOH || b == CH_STX) begin
                        body_length = (b == CH_SOH) ? 11'd128 : 11'd1024;
                        phase = PH_NUM;
                        tick_count = 0;
                    end else if (b == CH_EOT) begin
                        error_count = 0;
                        if (header_seen) begin
                            header_seen = 0;
                            send(CH_NAK);
                        end else begin
                            send(CH_ACK);
                            send(CH_POLL);
                        end
                        expected_block = 0;
                        tick_count = 0;
                    end else if (b == CH_CA) begin
                        phase = PH_CA2;
                        tick_count = 0;
                    end else if (b == CH_AB1 || b == CH_AB2) begin
                        cancel(ST_ABORT);
                    end else begin
                        error_event();
                    end
                end
                PH_CA2: begin
                    if (b == CH_CA) begin
                        error_count = 0;
                        send(CH_ACK);
                        end_session(ST_ABORT);
                    end else begin
                        error_event();
                    end
                end
                PH_NUM: begin
                    block_number = b;
                    phase = PH_CNUM;
                end
                PH_CNUM: begin
                    number_ok = (b == ~block_number);
                    crc_acc = 0;
                    byte_index = 0;
                    size_state = SP_NAME;
                    size_digits = 0;
                    size_value = 0;
                    header_empty = 0;
                    phase = PH_DATA;
                end
                PH_DATA: begin
                    crc_acc = crc_next(crc_acc, b);
                    if (number_ok && !number_mismatch()) begin
                        if (expected_block != 0)
                            emit(K_PAYLOAD, b, write_address + byte_index, 0, 0, 0);
                        else
                            parse_size(b);
                    end
                    byte_index++;
                    if (byte_index >= body_length) phase = PH_CRCH;
                end
                PH_CRCH: begin
                    rx_crc = {b, 8'h00};
                    phase = PH_CRCL;
                end
                PH_CRCL: begin
                    rx_crc[7:0] = b;
                    finish_packet();
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted input transfer.
        function void take_event(logic [1:0] func, logic [7:0] b, logic ok);
            step_res.delete();
            if (func == FN_BYTE) begin
                if (phase != PH_FLASH) on_byte(b);
            end else if (func == FN_TICK) begin
                if (phase != PH_FLASH) begin
                    if (tick_count < 16'hFFFF) tick_count++;
                    if (tick_count > timeout_ticks) error_event();
                end
            end else if (func == FN_FLASH) begin
                if (phase == PH_FLASH) begin
                    phase = PH_HDR;
                    tick_count = 0;
                    if (ok) begin
                        write_address += body_length;
                        send(CH_ACK);
                        expected_block++;
                        session_started = 1;
                    end else begin
                        cancel(ST_FLASH);
                    end
                end
            end
            if (step_res.size() > 0) step_res[$].last = 1;
            foreach (step_res[i]) due.push_back(step_res[i]);
        endfunction

        function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Called for every accepted output transfer.
        function void match_result(t_rx_result act);
            t_rx_result e;
            if (due.size() == 0) begin
                $error("result kind %0d arrived with nothing outstanding", act.kind);
                mismatches++;
                return;
            end
            e = due.pop_front();
            field_check("kind", e.kind, act.kind);
            field_check("byte_value", e.byte_value, act.byte_value);
            field_check("address", e.address, act.address);
            field_check("count", e.count, act.count);
            field_check("image_size", e.image_size, act.image_size);
            field_check("status", e.status, act.status);
            field_check("last", e.last, act.last);
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_func;
    logic [7:0]  i_rx_byte;
    logic        i_flash_ok;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid, i_stall;
    logic [2:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic [31:0] o_address;
    logic [10:0] o_count;
    logic [31:0] o_image_size;
    logic [1:0]  o_status;
    logic        o_last;

    ymodem_crc_receiver u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_rx_byte    (i_rx_byte),
        .i_flash_ok   (i_flash_ok),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_address    (o_address),
        .o_count      (o_count),
        .o_image_size (o_image_size),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    ymodem_receiver_mirror mirror = new();

    int          burst_left = 0;
    int          phase_items = 0;
    int          idle_cycles = 0;
    int          cycle_cnt = 0;
    int          stall_mode = 0;
    logic [7:0]  pkt_body[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver side: stall pattern is redrawn at random, now and then, among no stalls,
    // sparse random stalls and long periodic stalls.
    always @(negedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 256 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= (cycle_cnt % 16) < 9;
        endcase
    end

    // Output transfer check, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            mirror.match_result('{o_kind, o_byte_value, o_address, o_count,
                                  o_image_size, o_status, o_last});
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One input transfer; the sender runs in bursts separated by random gaps.
    task automatic push_event(logic [1:0] func, logic [7:0] b, logic ok);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_func = func;
        i_rx_byte = b;
        i_flash_ok = ok;
        do @(posedge i_clk); while (o_stall);
        mirror.take_event(func, b, ok);
        phase_items++;
    endtask

    // Holds the sender until every outstanding result has drained, plus slack for
    // events still in flight that make no result.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (mirror.due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mirror.write_reg(idx, val);
    endtask

    task automatic set_all(logic [31:0] base, logic [31:0] lim, logic [15:0] tmo,
                           logic [7:0] errs);
        drain();
        set_reg(CFG_BASE, base);
        set_reg(CFG_LIMIT, lim);
        set_reg(CFG_TIMEOUT, {16'h0, tmo});
        set_reg(CFG_ERRLIM, {24'h0, errs});
    endtask

    // Packet on the wire: header, block number and complement, body padded to
    // length, CRC (optionally flipped in one bit).
    task automatic send_packet(bit big, logic [7:0] blk, logic [7:0] cblk, bit bad_crc);
        int len;
        logic [15:0] crc;
        logic [7:0] b;
        len = big ? 1024 : 128;
        crc = 0;
        push_event(FN_BYTE, big ? CH_STX : CH_SOH, 1'b0);
        push_event(FN_BYTE, blk, 1'b0);
        push_event(FN_BYTE, cblk, 1'b0);
        for (int i = 0; i < len; i++) begin
            b = (i < pkt_body.size()) ? pkt_body[i] : 8'h00;
            crc = ymodem_receiver_mirror::crc_next(crc, b);
            push_event(FN_BYTE, b, 1'b0);
        end
        if (bad_crc) crc ^= 16'h1 << $urandom_range(0, 15);
        push_event(FN_BYTE, crc[15:8], 1'b0);
        push_event(FN_BYTE, crc[7:0], 1'b0);
    endtask

    // Header packet body: name, NUL, size text.
    task automatic header_text(string nm, string sz);
        pkt_body.delete();
        foreach (nm[i]) pkt_body.push_back(nm[i]);
        pkt_body.push_back(8'h00);
        foreach (sz[i]) pkt_body.push_back(sz[i]);
    endtask

    task automatic random_header();
        int sel, ndig;
        string suf;
        pkt_body.delete();
        sel = $urandom_range(0, 15);
        if (sel == 0) return;                      // empty name: end of batch
        if (sel == 1) begin                        // name never terminated
            repeat (128) pkt_body.push_back($urandom_range(1, 255));
            return;
        end
        repeat ($urandom_range(1, 10)) pkt_body.push_back($urandom_range("a", "z"));
        pkt_body.push_back(8'h00);
        ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
        repeat (ndig) pkt_body.push_back($urandom_range("0", "9"));
        case ($urandom_range(0, 7))
            0: suf = "k";
            1: suf = "K";
            2: suf = "m";
            3: suf = "M";
            4: suf = "#";
            5: suf = "";
            default: suf = " 1234";
        endcase
        foreach (suf[i]) pkt_body.push_back(suf[i]);
    endtask

    task automatic random_data();
        pkt_body.delete();
        repeat (128) pkt_body.push_back($urandom_range(0, 255));
    endtask

    // Answer a pending commit, sometimes after a few events that must be ignored.
    task automatic serve_flash();
        if (mirror.phase != PH_FLASH) return;
        repeat ($urandom_range(0, 2))
            push_event($urandom_range(0, 1), $urandom_range(0, 255), 1'b0);
        push_event(FN_FLASH, $urandom_range(0, 255), $urandom_range(0, 11) != 0);
    endtask

    task automatic run_session();
        int ends0, act;
        logic [7:0] blk;
        ends0 = mirror.ends;
        if ($urandom_range(0, 5) == 0) drain();
        random_header();
        send_packet(0, 8'h00, 8'hFF, $urandom_range(0, 9) == 0);
        repeat ($urandom_range(2, 6)) begin
            if (mirror.ends != ends0) return;
            act = $urandom_range(0, 13);
            blk = mirror.expected_block;
            random_data();
            case (act)
                0, 1, 2, 3, 4, 5: send_packet(0, blk, ~blk, 0);
                6: send_packet(0, blk, ~blk, 1);
                7: send_packet(0, blk, ~blk ^ (8'h1 << $urandom_range(0, 7)), 0);
                8: send_packet(0, blk - 8'd1, ~(blk - 8'd1), 0);
                9: repeat ($urandom_range(1, 4))
                    push_event($urandom_range(0, 3), $urandom_range(0, 255),
                               $urandom_range(0, 1));
                10: repeat ((mirror.timeout_ticks <= 20) ? mirror.timeout_ticks + 1 : 5)
                    push_event(FN_TICK, 8'h00, 1'b0);
                11: begin
                    push_event(FN_BYTE, CH_CA, 1'b0);
                    push_event(FN_BYTE, ($urandom_range(0, 3) == 0) ? CH_CA
                                        : $urandom_range(0, 255), 1'b0);
                end
                12: push_event(FN_BYTE, $urandom_range(0, 1) ? CH_AB1 : CH_AB2, 1'b0);
                default: push_event(FN_BYTE, CH_EOT, 1'b0);
            endcase
            serve_flash();
        end
        if (mirror.ends != ends0) return;
        push_event(FN_BYTE, CH_EOT, 1'b0);
        push_event(FN_BYTE, CH_EOT, 1'b0);
        pkt_body.delete();
        send_packet(0, 8'h00, 8'hFF, 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FN_BYTE;
        i_rx_byte = 8'h00;
        i_flash_ok = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = 32'h0;
        i_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: one full transfer with a 1K block, a bad CRC, a failed flash write.
        set_all(32'h0800_0000, 32'h0010_0000, 16'd3, 8'd2);
        header_text("fw.bin", "1234 ");
        send_packet(0, 8'h00, 8'hFF, 0);
        random_data();
        send_packet(1, 8'h01, 8'hFE, 0);
        push_event(FN_TICK, 8'h00, 1'b0);          // ignored during flash wait
        push_event(FN_FLASH, 8'h00, 1'b1);
        send_packet(0, 8'h02, 8'hFD, 1);          // discard, then C
        send_packet(0, 8'h01, 8'hFE, 0);          // repeated block -> NAK
        send_packet(0, 8'h02, 8'hFD, 0);
        push_event(FN_FLASH, 8'h00, 1'b0);        // flash error ends session

        push_event(FN_FLASH, 8'hFF, 1'b1);        // stray completion
        push_event(FN_SPARE, 8'hFF, 1'b1);
        push_event(FN_BYTE, CH_AB1, 1'b0);
        push_event(FN_BYTE, CH_AB2, 1'b0);
        push_event(FN_BYTE, CH_CA, 1'b0);
        push_event(FN_BYTE, CH_CA, 1'b0);
        push_event(FN_BYTE, CH_CA, 1'b0);
        push_event(FN_BYTE, 8'h55, 1'b0);         // CA then garbage
        repeat (4) push_event(FN_TICK, 8'h00, 1'b0);
        push_event(FN_BYTE, CH_EOT, 1'b0);        // EOT with no header
        push_event(FN_BYTE, 8'hFF, 1'b0);

        // Size text variants: suffixes, overlong, saturated above limit, empty name.
        header_text("a", "5M");
        send_packet(0, 8'h00, 8'hFF, 0);
        header_text("b", "2k");
        send_packet(0, 8'h00, 8'hFF, 0);
        header_text("c", "12345678901");
        send_packet(0, 8'h00, 8'hFF, 0);
        header_text("d", "9999999999");
        send_packet(0, 8'h00, 8'hFF, 0);
        header_text("e", "k");
        send_packet(0, 8'h00, 8'hFF, 0);
        pkt_body.delete();
        send_packet(0, 8'h00, 8'hFF, 0);

        // Random sessions under several register settings, extremes first.
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: set_all(32'hFFFF_FF00, 32'h0, 16'd1, 8'd0);
                1: set_all(32'h0, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
                2: set_all($urandom, 32'h0010_0000, 16'd8, 8'd3);
                default: set_all($urandom, $urandom, $urandom_range(1, 30),
                                 $urandom_range(0, 255));
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) run_session();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ymc_pkg.sv
hw/rtl/ymc_front.sv
hw/rtl/ymc_queue.sv
hw/rtl/ymc_back.sv
hw/rtl/ymodem_crc_receiver.sv
test/tb_ymodem_crc_receiver.sv
